FILE: rtl/u16u8_pkg.sv
// Shared types, constants and the UTF-8 encoder for the UTF-16BE to UTF-8 transcoder.
// Depends on nothing; every other file of the block imports it.
package u16u8_pkg;

    localparam int CMD_FIFO_DEPTH = 4;

    // One queued piece of work. It holds an optional flushed high surrogate that is
    // emitted first, and then an optional code point.
    typedef struct packed {
        logic        flush_vld;
        logic [9:0]  flush_bits;
        logic        unit_vld;
        logic [20:0] code_pt;
    } cmd_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } enc_t;

    function automatic enc_t utf8_enc(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = {1'b0, cp[6:0]};
            e.len  = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.len  = 3'd2;
        end else if (cp < 21'h10000) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.len  = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

endpackage

FILE: rtl/u16u8_front.sv
// Front end: pairs input bytes into UTF-16 units and resolves surrogate pairs.
// Depends on u16u8_pkg; hands one command per productive item to the queue.
module u16u8_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_take,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              push,
    output u16u8_pkg::cmd_t   cmd
);
    import u16u8_pkg::*;

    logic       pend_reg, pend_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       held_reg, held_next;
    logic [9:0] held_bits_reg, held_bits_next;
    logic [15:0] unit;
    logic        is_hi, is_lo;

    assign unit  = {pend_byte_reg, in_byte};
    assign is_hi = (unit[15:10] == 6'b110110);
    assign is_lo = (unit[15:10] == 6'b110111);

    always_comb begin
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        held_next      = held_reg;
        held_bits_next = held_bits_reg;
        cmd            = '0;
        cmd.flush_bits = held_bits_reg;
        if (in_take) begin
            if (!pend_reg) begin
                pend_next      = 1'b1;
                pend_byte_next = in_byte;
                cmd.flush_vld  = held_reg && in_last;
            end else begin
                pend_next = 1'b0;
                if (held_reg && is_lo) begin
                    // The offset 0x10000 plus the twenty surrogate payload bits.
                    cmd.unit_vld = 1'b1;
                    cmd.code_pt  = {1'b0, held_bits_reg, unit[9:0]} + 21'h10000;
                    held_next    = 1'b0;
                end else begin
                    cmd.flush_vld = held_reg;
                    if (is_hi && !in_last) begin
                        held_next      = 1'b1;
                        held_bits_next = unit[9:0];
                    end else begin
                        held_next    = 1'b0;
                        cmd.unit_vld = 1'b1;
                        cmd.code_pt  = {5'b0, unit};
                    end
                end
            end
            if (in_last) begin
                pend_next = 1'b0;
                held_next = 1'b0;
            end
        end
    end

    assign push = cmd.flush_vld || cmd.unit_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            held_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
        pend_byte_reg <= pend_byte_next;
        held_bits_reg <= held_bits_next;
    end

endmodule

FILE: rtl/u16u8_fifo.sv
// Short command queue between the front end and the byte emitter.
// Depends on u16u8_pkg for the command type.
module u16u8_fifo #(
    parameter int Depth = u16u8_pkg::CMD_FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u16u8_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output u16u8_pkg::cmd_t   head_cmd,
    output logic              empty,
    output logic              full
);
    import u16u8_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cmd_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CntW'(Depth));
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command queue read while empty");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count does not follow a lone write");

endmodule

FILE: rtl/u16u8_back.sv
// Back end: expands a queued command into UTF-8 bytes and sends them one per cycle while m_tready is high.
// Depends on u16u8_pkg for the command type and the encoder function.
module u16u8_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  u16u8_pkg::cmd_t   head_cmd,
    input  logic              head_vld,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);
    import u16u8_pkg::*;

    localparam int BufLen = 7;

    logic [7:0] bytes_reg [BufLen];
    logic [7:0] ld_bytes  [BufLen];
    logic [2:0] remain_reg, remain_next;
    logic [2:0] ld_len;
    logic       take_out;
    enc_t       fenc, uenc;

    assign fenc = utf8_enc({5'b0, 6'b110110, head_cmd.flush_bits});
    assign uenc = utf8_enc(head_cmd.code_pt);

    // A flushed high surrogate always takes three bytes ahead of the unit's bytes.
    always_comb begin
        ld_len = (head_cmd.flush_vld ? 3'd3 : 3'd0)
               + (head_cmd.unit_vld ? uenc.len : 3'd0);
        if (head_cmd.flush_vld) begin
            ld_bytes[0] = fenc.b[0];
            ld_bytes[1] = fenc.b[1];
            ld_bytes[2] = fenc.b[2];
            ld_bytes[3] = uenc.b[0];
            ld_bytes[4] = uenc.b[1];
            ld_bytes[5] = uenc.b[2];
            ld_bytes[6] = uenc.b[3];
        end else begin
            ld_bytes[0] = uenc.b[0];
            ld_bytes[1] = uenc.b[1];
            ld_bytes[2] = uenc.b[2];
            ld_bytes[3] = uenc.b[3];
            ld_bytes[4] = 8'h00;
            ld_bytes[5] = 8'h00;
            ld_bytes[6] = 8'h00;
        end
    end

    assign m_tvalid = (remain_reg != 3'd0);
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = (remain_reg == 3'd1);
    assign take_out = m_tvalid && m_tready;
    assign pop      = head_vld && ((remain_reg == 3'd0) || (m_tlast && take_out));

    always_comb begin
        remain_next = remain_reg;
        if (pop) begin
            remain_next = ld_len;
        end else if (take_out) begin
            remain_next = remain_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= 3'd0;
        end else begin
            remain_reg <= remain_next;
        end
        if (pop) begin
            bytes_reg <= ld_bytes;
        end else if (take_out) begin
            for (int i = 0; i < BufLen - 1; i++) begin
                bytes_reg[i] <= bytes_reg[i + 1];
            end
            bytes_reg[BufLen - 1] <= 8'h00;
        end
    end

    a_cmd_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (ld_len != 3'd0))
        else $error("queued command expands to no bytes");

endmodule

FILE: rtl/utf16be_to_utf8_transcoder.sv
// UTF-16BE to UTF-8 transcoder: takes one byte per item and sends one UTF-8 byte per item.
// Path: when the emitter is idle, a code unit's command is written into the command queue at the
// edge that accepts the input byte completing it, then loaded into the emitter's byte buffer.
// Throughput: one input item per cycle while the command queue has room; the byte
// emitter sends one output item per cycle while m_tready is high, which sets the sustained rate.
// Reset (aresetn low, synchronous) clears pairing state, the queue and the emitter.
module utf16be_to_utf8_transcoder #(
    parameter int CmdDepth = u16u8_pkg::CMD_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // string_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_end
);
    import u16u8_pkg::*;

    logic in_take, push, pop, q_empty, q_full;
    cmd_t push_cmd, head_cmd;

    assign s_tready = !q_full;
    assign in_take  = s_tvalid && s_tready;

    u16u8_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (in_take),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .push    (push),
        .cmd     (push_cmd)
    );

    u16u8_fifo #(
        .Depth (CmdDepth)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    u16u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .head_vld (!q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
